/* rtl/core/sts_pkg.sv */
// Shared types and constants for the sorted table search unit.
// No dependencies.
package sts_pkg;

    localparam int IDX_W   = 10;
    localparam int DATA_W  = 64;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic              is_search;
        logic [IDX_W-1:0]  index;
        logic [IDX_W-1:0]  low;
        logic [IDX_W-1:0]  high;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* rtl/core/sorted_table_binary_search_unit.sv */
// Top level of the sorted table search unit: front end, command queue,
// back end and table RAM. Uses sts_pkg, sts_front, sts_queue, sts_back, sts_ram.
//
//   channel   handshake             payload
//   input     start / busy          kind, entry_index, entry_value,
//                                   range_low, range_high, search_key
//   result    done (1-cycle strobe) found
//
// A load is written to the RAM as it leaves the queue. A search runs P
// probes in the back end (at most about log2(range)+1, so up to 11 for
// 1024 entries): each probe is one RAM read followed by one compare.
// The queue holds two commands, so busy rises only while two wait.
// Reset is asynchronous; the table RAM is not cleared. The result strobe
// cannot be held off by the receiver.
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic [sts_pkg::IDX_W-1:0]  entry_index,
    input  logic [sts_pkg::DATA_W-1:0] entry_value,
    input  logic [sts_pkg::IDX_W-1:0]  range_low,
    input  logic [sts_pkg::IDX_W-1:0]  range_high,
    input  logic [sts_pkg::DATA_W-1:0] search_key,
    output logic                       done,
    output logic                       found
);

    localparam int AW = $clog2(TABLE_DEPTH);

    sts_pkg::q_status_t         q_status;
    sts_pkg::cmd_t              push_cmd;
    sts_pkg::cmd_t              head;
    logic                       push;
    logic                       pop;
    logic                       ram_en;
    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic [sts_pkg::DATA_W-1:0] ram_wdata;
    logic [sts_pkg::DATA_W-1:0] ram_rdata;

    sts_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .search_key  (search_key),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    sts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    sts_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .done      (done),
        .found     (found)
    );

    sts_ram #(
        .WIDTH (sts_pkg::DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // every search ends in a return to idle, so results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobes in consecutive cycles");

    a_found_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !found)
        else $error("found raised without a result strobe");

    // the queue fills only through a transfer on the input side
    a_busy_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an input transfer");
`endif

endmodule

/* rtl/core/sts_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module sts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* rtl/core/sts_front.sv */
// Front end: takes input transfers, drops loads beyond the table and clips
// search ranges, then pushes commands into the queue. Uses sts_pkg.
module sts_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [sts_pkg::IDX_W-1:0]      entry_index,
    input  logic [sts_pkg::DATA_W-1:0]     entry_value,
    input  logic [sts_pkg::IDX_W-1:0]      range_low,
    input  logic [sts_pkg::IDX_W-1:0]      range_high,
    input  logic [sts_pkg::DATA_W-1:0]     search_key,
    input  sts_pkg::q_status_t             q_status,
    output logic                           push,
    output sts_pkg::cmd_t                  push_cmd
);

    localparam int MAX_IDX = TABLE_DEPTH - 1;

    logic is_search;
    logic load_ok;
    logic clip;

    always_comb
    begin
        is_search = (kind == sts_pkg::KIND_SEARCH);
        load_ok   = (int'(entry_index) <= MAX_IDX);
        clip      = (int'(range_high) > MAX_IDX);

        busy = q_status.full;
        push = start && !q_status.full && (is_search || load_ok);

        push_cmd.is_search = is_search;
        push_cmd.index     = entry_index;
        push_cmd.low       = range_low;
        // clip only fires when the table is shallower than the index field
        push_cmd.high      = clip ? sts_pkg::IDX_W'(MAX_IDX) : range_high;
        push_cmd.value     = is_search ? search_key : entry_value;
    end

endmodule

/* rtl/core/sts_queue.sv */
// Short command queue between front and back end.
// Uses sts_pkg.
module sts_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sts_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output sts_pkg::cmd_t      head,
    output sts_pkg::q_status_t status
);

    sts_pkg::cmd_t slots [sts_pkg::Q_DEPTH];

    logic [sts_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sts_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sts_pkg::Q_CW-1:0] count_reg, count_next;

    always_comb
    begin
        status.full  = (count_reg == sts_pkg::Q_CW'(sts_pkg::Q_DEPTH));
        status.empty = (count_reg == '0);
        head         = slots[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sts_pkg::Q_AW'(sts_pkg::Q_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sts_pkg::Q_AW'(sts_pkg::Q_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/sts_back.sv */
// Back end: executes queued loads and runs the halving search over the table
// RAM, one probe per read/compare pair. Uses sts_pkg.
module sts_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sts_pkg::cmd_t                     head,
    input  sts_pkg::q_status_t                q_status,
    output logic                              pop,
    output logic                              ram_en,
    output logic                              ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]    ram_addr,
    output logic [sts_pkg::DATA_W-1:0]        ram_wdata,
    input  logic [sts_pkg::DATA_W-1:0]        ram_rdata,
    output logic                              done,
    output logic                              found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = sts_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_CMP
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   found_reg, found_next;

    // bounds carry one extra bit: low can step one past the last index
    logic [IW:0]                low_reg, low_next;
    logic [IW:0]                high_reg, high_next;
    logic [IW-1:0]              mid_reg, mid_next;
    logic [sts_pkg::DATA_W-1:0] key_reg, key_next;
    logic [IW+1:0]              sum;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        found_next = 1'b0;
        low_next   = low_reg;
        high_next  = high_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        pop        = 1'b0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = AW'(head.index);
        ram_wdata  = head.value;
        sum        = {1'b0, low_reg} + {1'b0, high_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (head.is_search)
                    begin
                        low_next   = {1'b0, head.low};
                        high_next  = {1'b0, head.high};
                        key_next   = head.value;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        ram_en = 1'b1;
                        ram_we = 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                if (low_reg > high_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mid_next   = sum[IW:1];
                    ram_en     = 1'b1;
                    ram_addr   = AW'(sum[IW:1]);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                priority if (ram_rdata == key_reg)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if ($signed(ram_rdata) < $signed(key_reg))
                begin
                    low_next   = {1'b0, mid_reg} + 1'b1;
                    state_next = S_CHECK;
                end
                else if (mid_reg == '0)
                begin
                    // nothing below index zero: range is empty
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    high_next  = {1'b0, mid_reg} - 1'b1;
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
    end

    assign done  = done_reg;
    assign found = found_reg;

endmodule
